>>> rtl/tpd_pkg.sv
package tpd_pkg;

    // Screen geometry in pixels
    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 400;

    // Raw coordinate and register widths
    localparam int RAW_W  = 14;
    localparam int SPAN_W = RAW_W + 1;          // signed difference of two raw values
    localparam int PIX_W  = 16;

    // Signed width needed to hold the larger screen dimension
    localparam int SCR_MAX  = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int SCR_BITS = $clog2(SCR_MAX + 1) + 1;

    // Scaled numerator (raw - min) * size, signed
    localparam int NUM_W = SPAN_W + SCR_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    localparam logic [RAW_W-1:0] INVALID_COORD = 14'h3FFF;
    localparam int               STEP_LIMIT    = 20;

    // Register reset values
    localparam logic [RAW_W-1:0] X_MIN_RST = 14'd2100;
    localparam logic [RAW_W-1:0] X_MAX_RST = 14'd12300;
    localparam logic [RAW_W-1:0] Y_MIN_RST = 14'd1600;
    localparam logic [RAW_W-1:0] Y_MAX_RST = 14'd7960;

    // Register indexes
    localparam logic [1:0] REG_X_MIN = 2'd0;
    localparam logic [1:0] REG_X_MAX = 2'd1;
    localparam logic [1:0] REG_Y_MIN = 2'd2;
    localparam logic [1:0] REG_Y_MAX = 2'd3;

    // Header bits
    localparam int HDR_BIT   = 7;
    localparam int PROX_BIT  = 6;
    localparam int SW_GREY   = 1;
    localparam int SW_BLUE   = 2;
    localparam int SW_BARREL = 3;
    localparam int SW_TIP    = 4;

    // Draw mode codes
    localparam logic [1:0] DRAW_NONE = 2'd0;
    localparam logic [1:0] DRAW_PLOT = 2'd1;
    localparam logic [1:0] DRAW_LINE = 2'd2;

    // Axis select
    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    localparam int TDATA_W = 104;

    typedef struct packed {
        logic       wr_byte;    // store incoming word into packet buffer
        logic [1:0] byte_idx;
        logic       latch_pkt;  // last word of packet: capture raw x and y
        logic       load_axis;  // form numerator and span for one axis
        logic       axis;
        logic       div_start;
        logic       store_q;    // quotient done: scale, saturate, keep
        logic       smooth;
        logic       load_out;
    } tpd_cmd_t;

    typedef struct packed {
        logic hdr_bit;
        logic div_done;
        logic out_free;
    } tpd_status_t;

endpackage

>>> rtl/tpd_div.sv
module tpd_div
    import tpd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [SPAN_W-1:0] den,
    output logic                    done,
    output logic signed [NUM_W-1:0] quo
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [NUM_W-1:0]  q_reg, q_next;
    logic [SPAN_W-1:0] rem_reg, rem_next;
    logic [SPAN_W-1:0] den_reg, den_next;
    logic              neg_reg, neg_next;
    logic [SPAN_W:0]   rem_shift;
    logic              fits;

    // Restoring radix-2: one quotient bit per cycle on magnitudes
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        rem_shift = {rem_reg, q_reg[NUM_W-1]};
        fits      = (rem_shift >= {1'b0, den_reg});
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            q_next    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            den_next  = den[SPAN_W-1] ? SPAN_W'(-den) : SPAN_W'(den);
            rem_next  = '0;
            neg_next  = num[NUM_W-1] ^ den[SPAN_W-1];
        end else if (busy_reg) begin
            rem_next = fits ? SPAN_W'(rem_shift - {1'b0, den_reg}) : rem_shift[SPAN_W-1:0];
            q_next   = {q_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(q_reg) : $signed(q_reg);

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("divider done longer than one cycle");

endmodule

>>> rtl/tpd_dp.sv
module tpd_dp
    import tpd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  tpd_cmd_t           cmd,
    output tpd_status_t        status,
    input  logic [7:0]         s_tdata,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [RAW_W-1:0]   cfg_wdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata
);

    localparam logic signed [NUM_W-1:0] SCR_W_S = NUM_W'(SCREEN_WIDTH);
    localparam logic signed [NUM_W-1:0] SCR_H_S = NUM_W'(SCREEN_HEIGHT);
    localparam logic signed [NUM_W:0]   Y_TOP   = (NUM_W + 1)'(SCREEN_HEIGHT - 1);

    function automatic logic signed [PIX_W-1:0] sat_q(input logic signed [NUM_W:0] v);
        logic signed [NUM_W:0] hi;
        logic signed [NUM_W:0] lo;
        hi = (NUM_W + 1)'(32767);
        lo = -(NUM_W + 1)'(32768);
        if (v > hi)      sat_q = 16'sh7FFF;
        else if (v < lo) sat_q = 16'sh8000;
        else             sat_q = v[PIX_W-1:0];
    endfunction

    // (5*last + clamp(p - last)) / 5, truncating, saturated
    function automatic logic signed [PIX_W-1:0] smooth16(
        input logic signed [PIX_W-1:0] p,
        input logic signed [PIX_W-1:0] last
    );
        logic signed [PIX_W:0]   d;
        logic signed [5:0]       dc;
        logic [4:0]              mag;
        logic [2:0]              q;
        logic                    rem_nz;
        logic signed [3:0]       tq;
        logic signed [3:0]       adj;
        logic signed [PIX_W+2:0] sum5;
        logic signed [PIX_W+1:0] res;
        d = {p[PIX_W-1], p} - {last[PIX_W-1], last};
        if (d > (PIX_W + 1)'(STEP_LIMIT))       dc = 6'(STEP_LIMIT);
        else if (d < -(PIX_W + 1)'(STEP_LIMIT)) dc = -6'(STEP_LIMIT);
        else                                    dc = d[5:0];
        mag = dc[5] ? 5'(-dc) : dc[4:0];
        if (mag >= 5'd20)      q = 3'd4;
        else if (mag >= 5'd15) q = 3'd3;
        else if (mag >= 5'd10) q = 3'd2;
        else if (mag >= 5'd5)  q = 3'd1;
        else                   q = 3'd0;
        rem_nz = (mag != 5'({2'b00, q} * 5'd5));
        tq     = dc[5] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        sum5   = ((PIX_W + 3)'(last) <<< 2) + (PIX_W + 3)'(last) + (PIX_W + 3)'(dc);
        // truncation: floor when the sum is non-negative, ceiling otherwise
        if (!sum5[PIX_W+2]) adj = tq - 4'(dc[5] && rem_nz);
        else                adj = tq + 4'(!dc[5] && dc != 6'sd0 && rem_nz);
        res = (PIX_W + 2)'(last) + (PIX_W + 2)'(adj);
        if (res > (PIX_W + 2)'(32767))       smooth16 = 16'sh7FFF;
        else if (res < -(PIX_W + 2)'(32768)) smooth16 = 16'sh8000;
        else                                 smooth16 = res[PIX_W-1:0];
    endfunction

    logic [RAW_W-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic [7:0]       pkt_reg [4];
    logic [RAW_W-1:0] rx_reg, ry_reg;
    logic signed [NUM_W-1:0]  num_reg, num_next;
    logic signed [SPAN_W-1:0] span_reg, span_next;
    logic             zero_x_reg, zero_y_reg;
    logic signed [PIX_W-1:0] px_reg, py_reg;
    logic signed [PIX_W-1:0] last_x_reg, last_y_reg;
    logic             cleared_reg;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0] m_tdata_reg;

    logic [RAW_W-1:0]         raw_sel, min_sel, max_sel;
    logic signed [SPAN_W-1:0] diff;
    logic signed [NUM_W-1:0]  quo;
    logic                     div_done;
    logic                     valid;
    logic                     all_sw;
    logic [1:0]               mode;
    logic [7:0]               flags;

    tpd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (num_reg),
        .den     (span_reg),
        .done    (div_done),
        .quo     (quo)
    );

    assign flags = pkt_reg[0];

    always_comb begin
        raw_sel   = (cmd.axis == AXIS_X) ? rx_reg    : ry_reg;
        min_sel   = (cmd.axis == AXIS_X) ? x_min_reg : y_min_reg;
        max_sel   = (cmd.axis == AXIS_X) ? x_max_reg : y_max_reg;
        diff      = $signed({1'b0, raw_sel}) - $signed({1'b0, min_sel});
        span_next = $signed({1'b0, max_sel}) - $signed({1'b0, min_sel});
        num_next  = NUM_W'(diff) * ((cmd.axis == AXIS_X) ? SCR_W_S : SCR_H_S);
    end

    always_comb begin
        valid  = !zero_x_reg && !zero_y_reg && rx_reg != INVALID_COORD
                 && ry_reg != INVALID_COORD;
        all_sw = (flags[4:0] == 5'h1F);
        if (valid && (flags[SW_TIP] || flags[SW_BARREL]))
            mode = flags[SW_GREY] ? DRAW_LINE : DRAW_PLOT;
        else
            mode = DRAW_NONE;
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_min_reg    <= X_MIN_RST;
            x_max_reg    <= X_MAX_RST;
            y_min_reg    <= Y_MIN_RST;
            y_max_reg    <= Y_MAX_RST;
            last_x_reg   <= '0;
            last_y_reg   <= '0;
            cleared_reg  <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_X_MIN: x_min_reg <= cfg_wdata;
                    REG_X_MAX: x_max_reg <= cfg_wdata;
                    REG_Y_MIN: y_min_reg <= cfg_wdata;
                    REG_Y_MAX: y_max_reg <= cfg_wdata;
                    default:   x_min_reg <= x_min_reg;
                endcase
            end
            if (cmd.load_out) begin
                last_x_reg  <= px_reg;
                last_y_reg  <= py_reg;
                cleared_reg <= all_sw;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_byte)
            pkt_reg[cmd.byte_idx] <= s_tdata;
        if (cmd.latch_pkt) begin
            rx_reg <= {pkt_reg[2][6:0], pkt_reg[1][6:0]};
            ry_reg <= {s_tdata[6:0], pkt_reg[3][6:0]};
        end
        if (cmd.load_axis) begin
            num_reg  <= num_next;
            span_reg <= span_next;
            if (cmd.axis == AXIS_X) zero_x_reg <= (span_next == '0);
            else                    zero_y_reg <= (span_next == '0);
        end
        if (cmd.store_q) begin
            if (cmd.axis == AXIS_X)
                px_reg <= zero_x_reg ? '0 : sat_q((NUM_W + 1)'(quo));
            else
                py_reg <= zero_y_reg ? '0 : sat_q(Y_TOP - (NUM_W + 1)'(quo));
        end
        if (cmd.smooth && flags[SW_BLUE]) begin
            px_reg <= smooth16(px_reg, last_x_reg);
            py_reg <= smooth16(py_reg, last_y_reg);
        end
        if (cmd.load_out) begin
            m_tdata_reg <= {2'b00,
                            all_sw && !cleared_reg,
                            !flags[PROX_BIT],
                            mode,
                            py_reg, px_reg,
                            last_y_reg, last_x_reg,
                            valid,
                            ry_reg, rx_reg,
                            flags[4:0]};
        end
    end

    assign status.hdr_bit  = s_tdata[HDR_BIT];
    assign status.div_done = div_done;
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("pending result overwritten");

    a_last_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> (last_x_reg == $past(px_reg) && last_y_reg == $past(py_reg)))
        else $error("last pixel not updated from result");

endmodule

>>> rtl/tpd_ctrl.sv
module tpd_ctrl
    import tpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  tpd_status_t status,
    output tpd_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_START,
        S_WAIT,
        S_SMOOTH,
        S_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] pos_reg, pos_next;
    logic       axis_reg, axis_next;

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        cmd.byte_idx = pos_reg[1:0];
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (pos_reg == 3'd0) begin
                        // hunting: only a header word opens a packet
                        if (status.hdr_bit) begin
                            cmd.wr_byte = 1'b1;
                            pos_next    = 3'd1;
                        end
                    end else if (pos_reg == 3'd4) begin
                        cmd.latch_pkt = 1'b1;
                        pos_next      = 3'd0;
                        axis_next     = AXIS_X;
                        state_next    = S_LOAD;
                    end else begin
                        cmd.wr_byte = 1'b1;
                        pos_next    = pos_reg + 3'd1;
                    end
                end
            end
            S_LOAD: begin
                cmd.load_axis = 1'b1;
                state_next    = S_START;
            end
            S_START: begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT: begin
                if (status.div_done) begin
                    cmd.store_q = 1'b1;
                    if (axis_reg == AXIS_X) begin
                        axis_next  = AXIS_Y;
                        state_next = S_LOAD;
                    end else begin
                        state_next = S_SMOOTH;
                    end
                end
            end
            S_SMOOTH: begin
                cmd.smooth = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pos_reg   <= 3'd0;
            axis_reg  <= AXIS_X;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            axis_reg  <= axis_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= 3'd4)
        else $error("byte position out of range");

    a_hunt_after_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.latch_pkt |=> (pos_reg == 3'd0 && state_reg == S_LOAD))
        else $error("packet end did not restart hunting");

endmodule

>>> rtl/tablet_packet_decoder.sv
// Tablet packet decoder.
// Input stream (s_): one received serial word per beat, s_tdata[7:0] = rx_byte.
// A header word (bit 7 set) opens a packet; four more words complete it.
// Words outside a packet without bit 7 are dropped. Each complete packet gives
// one result word on the m_ stream with the switches, raw coordinates, scaled
// and optionally smoothed pixel position, draw mode, proximity and a
// clear-screen pulse.
// Throughput: the first four words of a packet are taken one per cycle. After
// the fifth word s_tready drops while both axes go through one shared radix-2
// divider, one quotient bit per cycle: x first, then y, then optional smoothing.
// The result sits in an output register; header and data words of the next
// packet are taken while it waits. If the receiver stalls, the next result
// waits in the decoder until m_tready frees the register.
// Registers x_min, x_max, y_min, y_max are written through cfg_wr_en/cfg_addr.
// Reset (aresetn low, synchronous) restores the default calibration, returns
// to header hunting, clears the last pixel to 0,0 and empties the output.
module tablet_packet_decoder
    import tpd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // [7:0] rx_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    // [4:0] buttons, [18:5] raw_x, [32:19] raw_y, [33] point_valid,
    // [49:34] from_x, [65:50] from_y, [81:66] to_x, [97:82] to_y,
    // [99:98] draw_mode, [100] in_proximity, [101] clear_screen, [103:102] zero
    output logic [TDATA_W-1:0] m_tdata,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [RAW_W-1:0]   cfg_wdata
);

    tpd_cmd_t    cmd;
    tpd_status_t status;

    tpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tpd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
